FILE: rtl/fbpa_pkg.sv
// Shared types and constants of the fixed block pool allocator.
package fbpa_pkg;

  localparam int ADDR_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int BPB_W      = 16;
  localparam int BIN_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd2;

  localparam logic [ADDR_W-1:0]    RST_POOL_BASE   = 32'd0;
  localparam logic [BPB_W-1:0]     RST_BLOCK_BYTES = 16'd64;
  localparam logic [BIN_W-1:0]     RST_BLOCK_COUNT = 7'd64;

  // divider retires two quotient bits per cycle
  localparam int DIV_BITS_PER_CYC = 2;
  localparam int DIV_STEPS        = ADDR_W / DIV_BITS_PER_CYC;
  localparam int DIV_CNT_W        = $clog2(DIV_STEPS);

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } fbpa_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_MUL,
    ST_OUT
  } fbpa_state_t;

  typedef struct packed {
    logic         take;
    logic         div_start;
    logic         scan_rd;
    logic         scan_chk;
    logic         row_inc;
    logic         free_rd;
    logic         free_wr;
    logic         mul;
    logic         res_load;
    fbpa_status_t res_code;
  } fbpa_cmd_t;

  typedef struct packed {
    logic bpb_zero;
    logic div_done;
    logic hit;
    logic last_row;
    logic in_range;
    logic out_busy;
  } fbpa_sts_t;

endpackage

FILE: rtl/fbpa_ifs.sv
// Handshake channel interfaces: request, result and configuration write.
interface fbpa_in_if import fbpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [ADDR_W-1:0] free_address;

  modport source (output valid, output opcode, output free_address, input ready);
  modport sink   (input valid, input opcode, input free_address, output ready);
endinterface

interface fbpa_out_if import fbpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   block_address;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output block_address, output status, input ready);
  modport sink   (input valid, input block_address, input status, output ready);
endinterface

interface fbpa_cfg_if import fbpa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/fbpa_div.sv
// Restoring divider, 32-bit dividend by 16-bit divisor, two bits per cycle.
module fbpa_div import fbpa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [ADDR_W-1:0] dividend,
  input  logic [BPB_W-1:0]  divisor,
  output logic              done,
  output logic [ADDR_W-1:0] quotient
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] step_r, step_nxt;
  logic [ADDR_W-1:0]    num_r, num_nxt;
  logic [BPB_W-1:0]     rem_r, rem_nxt;
  logic [BPB_W-1:0]     dvs_r;

  logic [BPB_W:0]    t1, t2, r1, r2;
  logic              ge1, ge2;
  logic [ADDR_W-1:0] n1, n2;

  always_comb begin
    t1  = {rem_r, num_r[ADDR_W-1]};
    ge1 = t1 >= {1'b0, dvs_r};
    r1  = ge1 ? t1 - {1'b0, dvs_r} : t1;
    n1  = {num_r[ADDR_W-2:0], ge1};
    t2  = {r1[BPB_W-1:0], n1[ADDR_W-1]};
    ge2 = t2 >= {1'b0, dvs_r};
    r2  = ge2 ? t2 - {1'b0, dvs_r} : t2;
    n2  = {n1[ADDR_W-2:0], ge2};
  end

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      num_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      num_nxt  = n2;
      rem_nxt  = r2[BPB_W-1:0];
      step_nxt = step_r + 1'b1;
      if (step_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = num_r;

endmodule

FILE: rtl/fbpa_dp.sv
// Datapath: config registers, used-flag memory, divider, address math, result register.
module fbpa_dp import fbpa_pkg::*; #(
  parameter int MAX_BLOCKS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  fbpa_cfg_if.sink          cfg_if,
  input  logic              in_opcode,
  input  logic [ADDR_W-1:0] in_free_address,
  fbpa_out_if.source        out_if,
  input  fbpa_cmd_t         cmd,
  output fbpa_sts_t         sts
);

  localparam int WORD  = (MAX_BLOCKS < 32) ? MAX_BLOCKS : 32;
  localparam int BIT_W = (WORD > 1) ? $clog2(WORD) : 1;
  localparam int ROWS  = (MAX_BLOCKS + WORD - 1) / WORD;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CNT_B = $clog2(MAX_BLOCKS + 1);
  localparam int KW    = ((CNT_B > BIN_W) ? CNT_B : BIN_W) + 1;

  logic [ADDR_W-1:0] base_r;
  logic [BPB_W-1:0]  bpb_r;
  logic [BIN_W-1:0]  nblk_r;

  logic              opcode_r;
  logic [ROW_W-1:0]  row_r;
  logic [KW-1:0]     idx_r;
  logic [KW+15:0]    prod_r;

  logic [WORD-1:0]   flag_mem [ROWS];
  logic [ROWS-1:0]   rv_r;
  logic [WORD-1:0]   rd_data_r;
  logic              rd_vld_r;

  logic                out_valid_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic [STATUS_W-1:0] out_status_r;

  logic              div_done;
  logic [ADDR_W-1:0] quot;

  logic [KW-1:0]     count_w, row_base, lim;
  logic [WORD-1:0]   eff_word, mask, free_bits, wr_data;
  logic [BIT_W-1:0]  hit_bit, free_bit;
  logic [ROW_W-1:0]  free_row, rd_addr, wr_addr;
  logic              hit, last_row, rd_en, wr_en;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= RST_POOL_BASE;
      bpb_r  <= RST_BLOCK_BYTES;
      nblk_r <= RST_BLOCK_COUNT;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_POOL_BASE:   base_r <= cfg_if.data;
        CFG_BLOCK_BYTES: bpb_r  <= cfg_if.data[BPB_W-1:0];
        CFG_BLOCK_COUNT: nblk_r <= cfg_if.data[BIN_W-1:0];
        default: ;
      endcase
    end
  end

  fbpa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (in_free_address - base_r),
    .divisor  (bpb_r),
    .done     (div_done),
    .quotient (quot)
  );

  always_comb begin
    count_w  = (KW'(nblk_r) > KW'(MAX_BLOCKS)) ? KW'(MAX_BLOCKS) : KW'(nblk_r);
    row_base = KW'(row_r * WORD);
    lim      = (count_w > row_base) ? count_w - row_base : '0;
    last_row = (row_base + KW'(WORD) >= count_w) || (row_r == ROW_W'(ROWS - 1));
    eff_word = rd_vld_r ? rd_data_r : '0;
    for (int b = 0; b < WORD; b++) begin
      mask[b] = KW'(b) < lim;
    end
    free_bits = ~eff_word & mask;
    hit       = |free_bits;
    hit_bit   = '0;
    for (int b = WORD - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        hit_bit = BIT_W'(b);
      end
    end
    free_bit = quot[BIT_W-1:0];
    free_row = (ROWS == 1) ? '0 : quot[BIT_W +: ROW_W];
  end

  assign rd_en   = cmd.scan_rd | cmd.free_rd;
  assign rd_addr = cmd.scan_rd ? row_r : free_row;
  assign wr_en   = (cmd.scan_chk & hit) | cmd.free_wr;
  assign wr_addr = cmd.free_wr ? free_row : row_r;
  assign wr_data = cmd.free_wr ? (eff_word & ~(WORD'(1) << free_bit))
                               : (eff_word | (WORD'(1) << hit_bit));

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= flag_mem[rd_addr];
    end
    if (wr_en) begin
      flag_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r     <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld_r <= rv_r[rd_addr];
      end
      if (wr_en) begin
        rv_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      opcode_r <= in_opcode;
      row_r    <= '0;
    end else if (cmd.row_inc) begin
      row_r <= row_r + 1'b1;
    end
    if (cmd.scan_chk && hit) begin
      idx_r <= row_base + KW'(hit_bit);
    end
    if (cmd.mul) begin
      prod_r <= idx_r * bpb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_addr_r   <= (cmd.res_code == STAT_DONE && opcode_r == OP_ALLOC)
                      ? base_r + ADDR_W'(prod_r) : '0;
      out_status_r <= cmd.res_code;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.block_address = out_addr_r;
  assign out_if.status        = out_status_r;

  assign sts.bpb_zero = bpb_r == '0;
  assign sts.div_done = div_done;
  assign sts.hit      = hit;
  assign sts.last_row = last_row;
  assign sts.in_range = quot < ADDR_W'(count_w);
  assign sts.out_busy = out_valid_r & ~out_if.ready;

endmodule

FILE: rtl/fbpa_ctrl.sv
// Controller state machine sequencing allocate and free requests.
module fbpa_ctrl import fbpa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_opcode,
  output logic      in_ready,
  input  fbpa_sts_t sts,
  output fbpa_cmd_t cmd
);

  fbpa_state_t  state_r, state_nxt;
  fbpa_status_t res_r, res_nxt;

  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_opcode == OP_FREE) begin
            if (sts.bpb_zero) begin
              state_nxt = ST_OUT;
              res_nxt   = STAT_RANGE;
            end else begin
              state_nxt = ST_DIV;
            end
          end else begin
            state_nxt = ST_SCAN_RD;
          end
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          if (sts.in_range) begin
            state_nxt = ST_FREE_RD;
          end else begin
            state_nxt = ST_OUT;
            res_nxt   = STAT_RANGE;
          end
        end
      end
      ST_FREE_RD: state_nxt = ST_FREE_WR;
      ST_FREE_WR: begin
        state_nxt = ST_OUT;
        res_nxt   = STAT_DONE;
      end
      ST_SCAN_RD: state_nxt = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (sts.hit) begin
          state_nxt = ST_MUL;
          res_nxt   = STAT_DONE;
        end else if (sts.last_row) begin
          state_nxt = ST_OUT;
          res_nxt   = STAT_FULL;
        end else begin
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_MUL: state_nxt = ST_OUT;
      ST_OUT: begin
        if (!sts.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = state_r == ST_IDLE;
    cmd           = '0;
    cmd.take      = (state_r == ST_IDLE) && in_valid;
    cmd.div_start = cmd.take && (in_opcode == OP_FREE) && !sts.bpb_zero;
    cmd.scan_rd   = state_r == ST_SCAN_RD;
    cmd.scan_chk  = state_r == ST_SCAN_CHK;
    cmd.row_inc   = (state_r == ST_SCAN_CHK) && !sts.hit && !sts.last_row;
    cmd.free_rd   = state_r == ST_FREE_RD;
    cmd.free_wr   = state_r == ST_FREE_WR;
    cmd.mul       = state_r == ST_MUL;
    cmd.res_load  = (state_r == ST_OUT) && !sts.out_busy;
    cmd.res_code  = res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      res_r   <= STAT_DONE;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

endmodule

FILE: rtl/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator.
// Hands out and takes back equal-sized blocks of a pool tracked by one used flag per
// block, kept in a memory of rows of up to 32 flags whose per-row valid bits clear at
// reset (no clearing pass). An allocate scans rows from the lowest, each row read and
// then checked, then multiplies the found index by the block size and adds the base.
// A free subtracts the base and divides by the block size in a divider that retires
// two quotient bits per cycle, then read-modifies-writes the flag row.
// One item is worked at a time; a new item is taken while the previous result waits
// in the output register. Configuration writes are always ready and must only be
// issued while the block is idle.
module fixed_block_pool_allocator import fbpa_pkg::*; #(
  parameter int MAX_BLOCKS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  fbpa_in_if.sink    in_if,
  fbpa_out_if.source out_if,
  fbpa_cfg_if.sink   cfg_if
);

  fbpa_cmd_t cmd;
  fbpa_sts_t sts;

  fbpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_opcode (in_if.opcode),
    .in_ready  (in_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fbpa_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_if          (cfg_if),
    .in_opcode       (in_if.opcode),
    .in_free_address (in_if.free_address),
    .out_if          (out_if),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

FILE: tb/sv/tb_fixed_block_pool_allocator.sv
`timescale 1ns / 1ps
// Testbench of the fixed block pool allocator: directed and random requests against a pool model.
module tb_fixed_block_pool_allocator;
  import fbpa_pkg::*;

  localparam int POOL_BLOCKS  = 64;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 110;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum int {RX_OPEN, RX_CHOPPY, RX_SLOW} rx_mode_t;

  typedef struct packed {
    logic [ADDR_W-1:0] block_address;
    fbpa_status_t      status;
  } grant_t;

  logic clk = 1'b0;
  logic rst_n;

  fbpa_in_if  in_if();
  fbpa_out_if out_if();
  fbpa_cfg_if cfg_if();

  fixed_block_pool_allocator #(.MAX_BLOCKS(POOL_BLOCKS)) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if),
    .cfg_if(cfg_if)
  );

  logic [ADDR_W-1:0]      pool_base;
  logic [BPB_W-1:0]       blk_bytes;
  logic [BIN_W-1:0]       blk_count;
  logic [POOL_BLOCKS-1:0] pool_used;

  grant_t grant_q[$];
  int     err_cnt    = 0;
  int     cycle_cnt  = 0;
  int     burst_left = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned managed_blocks();
    return (blk_count > POOL_BLOCKS) ? POOL_BLOCKS : int'(blk_count);
  endfunction

  // Applies one request to the pool copy and returns the result it should produce.
  function automatic grant_t pool_serve(logic op, logic [ADDR_W-1:0] addr);
    grant_t            g;
    logic [ADDR_W-1:0] offset;
    logic [ADDR_W-1:0] slot;
    logic              found;
    int unsigned       lim;
    lim = managed_blocks();
    g.block_address = '0;
    found = 1'b0;
    if (op == OP_ALLOC) begin
      g.status = STAT_FULL;
      for (int i = 0; i < lim; i++) begin
        if (!found && !pool_used[i]) begin
          found = 1'b1;
          pool_used[i] = 1'b1;
          g.block_address = pool_base + 32'(i) * 32'(blk_bytes);
          g.status = STAT_DONE;
        end
      end
    end else begin
      g.status = STAT_RANGE;
      offset = addr - pool_base;
      if (blk_bytes != '0) begin
        slot = offset / 32'(blk_bytes);
        if (slot < lim) begin
          pool_used[slot] = 1'b0;
          g.status = STAT_DONE;
        end
      end
    end
    return g;
  endfunction

  task automatic issue(logic op, logic [ADDR_W-1:0] addr);
    in_if.valid        <= 1'b1;
    in_if.opcode       <= op;
    in_if.free_address <= addr;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    grant_q.push_back(pool_serve(op, addr));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 20) : $urandom_range(6, 0);
      in_if.valid        <= 1'b0;
      in_if.opcode       <= 1'($urandom);
      in_if.free_address <= $urandom;
      repeat ($urandom_range(30, 1)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      CFG_POOL_BASE:   pool_base = data;
      CFG_BLOCK_BYTES: blk_bytes = data[BPB_W-1:0];
      CFG_BLOCK_COUNT: blk_count = data[BIN_W-1:0];
      default: ;
    endcase
  endtask

  // Upper data bits beyond each register's width carry random junk.
  task automatic set_pool(logic [ADDR_W-1:0] base, logic [BPB_W-1:0] bytes,
                          logic [BIN_W-1:0] count);
    drain();
    cfg_write(CFG_POOL_BASE, base);
    cfg_write(CFG_BLOCK_BYTES, {16'($urandom), bytes});
    cfg_write(CFG_BLOCK_COUNT, {25'($urandom), count});
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_reset_pool();
    issue(OP_ALLOC, 32'hFFFF_FFFF);
    issue(OP_ALLOC, 32'h0000_0000);
    issue(OP_FREE, 32'd127);
    issue(OP_FREE, 32'd127);
    issue(OP_FREE, 32'd4096);
    issue(OP_FREE, 32'hFFFF_FFFF);
    issue(OP_ALLOC, 32'h0000_0000);
  endtask

  task automatic test_wrap_addresses();
    set_pool(32'hFFFF_FF00, 16'hFFFF, 7'd3);
    issue(OP_ALLOC, 32'h0);
    issue(OP_ALLOC, 32'h0);
    issue(OP_FREE, 32'h0000_FF04);
    issue(OP_FREE, 32'h0000_0010);
    issue(OP_FREE, 32'hFFFF_FEFF);
    issue(OP_ALLOC, 32'h0);
    issue(OP_ALLOC, 32'h0);
  endtask

  task automatic test_degenerate_pools();
    set_pool(32'h8000_0000, 16'd0, 7'd64);
    issue(OP_ALLOC, 32'h0);
    issue(OP_ALLOC, 32'h0);
    issue(OP_FREE, 32'h8000_0000);
    set_pool(32'h0, 16'd1, 7'd0);
    issue(OP_ALLOC, 32'h0);
    issue(OP_FREE, 32'h0);
    set_pool(32'h0, 16'd1, 7'h7F);
    issue(OP_FREE, 32'd63);
    issue(OP_FREE, 32'd64);
    issue(OP_ALLOC, 32'h0);
    drain();
    cfg_write(CFG_SPARE, 32'hFFFF_FFFF);
    cfg_if.valid <= 1'b0;
    issue(OP_ALLOC, 32'h0);
  endtask

  task automatic test_random_traffic();
    logic [ADDR_W-1:0] base;
    logic [BPB_W-1:0]  bytes;
    logic [BIN_W-1:0]  count;
    logic [ADDR_W-1:0] where;
    int unsigned       lim;
    int unsigned       pick;
    int unsigned       slot;
    int unsigned       start;
    for (int phase = 0; phase < PHASES; phase++) begin
      case ($urandom_range(3, 0))
        0:       base = '0;
        1:       base = '1;
        default: base = $urandom;
      endcase
      case ($urandom_range(5, 0))
        0:       bytes = 16'd1;
        1:       bytes = 16'hFFFF;
        2:       bytes = 16'd0;
        default: bytes = BPB_W'($urandom_range(600, 1));
      endcase
      case ($urandom_range(5, 0))
        0:       count = 7'd1;
        1:       count = 7'd64;
        2:       count = 7'h7F;
        3:       count = 7'd0;
        default: count = BIN_W'($urandom_range(63, 2));
      endcase
      set_pool(base, bytes, count);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        lim  = managed_blocks();
        pick = $urandom_range(99, 0);
        slot = lim;
        if (lim != 0) begin
          start = $urandom_range(lim - 1, 0);
          for (int k = 0; k < lim; k++)
            if (slot == lim && pool_used[(start + k) % lim]) slot = (start + k) % lim;
        end
        if (pick < 50) begin
          issue(OP_ALLOC, $urandom);
        end else if (pick < 88 && slot < lim) begin
          // free a block in use, anywhere inside it
          where = pool_base + 32'(slot) * 32'(blk_bytes)
                + ((blk_bytes == '0) ? 32'd0 : 32'($urandom_range(blk_bytes - 1, 0)));
          issue(OP_FREE, where);
        end else begin
          case ($urandom_range(3, 0))
            0:       where = $urandom;
            1:       where = pool_base - 32'($urandom_range(255, 1));
            2:       where = pool_base + 32'(lim) * 32'(blk_bytes) + 32'($urandom_range(3, 0));
            default: where = pool_base + 32'($urandom_range(POOL_BLOCKS - 1, 0)) * 32'(blk_bytes);
          endcase
          issue(OP_FREE, where);
        end
      end
    end
  endtask

  always @(posedge clk) begin : check_result
    grant_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (grant_q.size() == 0) begin
        err_cnt++;
        $display("%0t: result with nothing expected: block_address %h status %0d",
                 $time, out_if.block_address, out_if.status);
      end else begin
        want = grant_q.pop_front();
        if (out_if.block_address !== want.block_address) begin
          err_cnt++;
          $display("%0t: block_address expected %h actual %h",
                   $time, want.block_address, out_if.block_address);
        end
        if (out_if.status !== want.status) begin
          err_cnt++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_if.status);
        end
      end
    end
  end

  initial begin : result_stalls
    rx_mode_t mode;
    int       left;
    mode = RX_OPEN;
    left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = rx_mode_t'($urandom_range(2, 0));
        left = $urandom_range(300, 40);
      end else begin
        left--;
      end
      case (mode)
        RX_OPEN:   out_if.ready <= 1'b1;
        RX_CHOPPY: out_if.ready <= 1'($urandom);
        default:   out_if.ready <= ($urandom_range(5, 0) == 0);
      endcase
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    pool_base = RST_POOL_BASE;
    blk_bytes = RST_BLOCK_BYTES;
    blk_count = RST_BLOCK_COUNT;
    pool_used = '0;
    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.opcode       <= OP_ALLOC;
    in_if.free_address <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= CFG_POOL_BASE;
    cfg_if.data        <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_pool();
    test_wrap_addresses();
    test_degenerate_pools();
    test_random_traffic();
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
